[rtl/core/open_addressing_hash_table_defines.svh]
// Assertion macros shared by the table RTL.
`ifndef OPEN_ADDRESSING_HASH_TABLE_DEFINES_SVH
`define OPEN_ADDRESSING_HASH_TABLE_DEFINES_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define OAHT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define OAHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/oaht_pkg.sv]
// ---------------------------------------------------------------------------
// oaht_pkg
// Types and codes shared by the open addressing hash table.
// ---------------------------------------------------------------------------
package oaht_pkg;

	// number of slots; a power of two, so the probe start is the low hash bits
	localparam int CAPACITY = 256;

	typedef enum logic [1:0] {
		ACT_SET = 2'd0,
		ACT_GET = 2'd1,
		ACT_DEL = 2'd2,
		ACT_CLR = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_WRITE,
		ST_CLEAR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] key_id;
		logic [31:0] key_hash;
		logic [63:0] write_value;
	} in_item_t;

	typedef struct packed {
		logic        hit;
		logic [63:0] read_value;
		logic        status;
	} out_item_t;

	localparam logic [8:0] MAX_USED_RESET = 9'd192;

endpackage

[rtl/core/open_addressing_hash_table.sv]
// ---------------------------------------------------------------------------
// open_addressing_hash_table
// Linear probing key/value table with tombstones, one item at a time.
// ---------------------------------------------------------------------------
// One item is in work at a time. A get, set or delete reads each probed slot
// (synchronous read in READ, then compare in CHECK), writes in WRITE, loads
// the output register in DONE and goes back to idle, where the next item is
// taken. A clear, and the pass after reset, sweep the slot-state memory one
// entry a cycle, then pass through DONE and idle; no item is taken during
// the sweep or DONE. The result sits in an output register, so the next
// item is taken and probed while it waits; only the load of the following
// result waits for it. max_used is written through the cfg channel; the
// user is to write it only while idle, the block itself does not enforce it.
`include "open_addressing_hash_table_defines.svh"

module open_addressing_hash_table (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  oaht_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output oaht_pkg::out_item_t  out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [8:0]           cfg_data
);

	localparam int CAPACITY = oaht_pkg::CAPACITY;
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = AW + 1;
	localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

	// slot state: {live, tomb}; key and value memories
	logic [1:0]  st_mem [CAPACITY];
	logic [31:0] key_mem [CAPACITY];
	logic [63:0] val_mem [CAPACITY];

	oaht_pkg::state_t state_q, state_nx;
	oaht_pkg::in_item_t item_q;
	logic [AW-1:0] idx_q, tomb_at_q, wr_at_q;
	logic [CW-1:0] steps_q;
	logic          tomb_seen_q;
	logic [8:0]    used_q, max_used_q;
	logic [1:0]    st_rd_q;
	logic [31:0]   key_rd_q;
	logic [63:0]   val_rd_q;
	logic          out_valid_q;
	logic          boot_q;
	oaht_pkg::out_item_t out_q, res_q, res_nx;

	// write-phase controls set at check time
	logic wr_live_q, wr_tomb_q, wr_kv_q, wr_inc_q;

	logic accept_in, out_free, live, tomb, key_eq, last_step, can_new;
	logic key_found, walk_end, act_set, ins_ok;
	logic [AW-1:0] idx_nx;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != oaht_pkg::ST_IDLE);
	assign accept_in = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign live      = st_rd_q[1];
	assign tomb      = st_rd_q[0];
	assign key_eq    = (key_rd_q == item_q.key_id);
	assign last_step = (steps_q == CW'(CAPACITY - 1));
	assign idx_nx    = (idx_q == LAST) ? '0 : idx_q + AW'(1);
	assign can_new   = (used_q < max_used_q);

	// probe outcome for the slot under check
	assign key_found = live && key_eq;
	assign walk_end  = (!live && !tomb) || last_step;
	assign act_set   = (item_q.action == oaht_pkg::ACT_SET);
	assign ins_ok    = !key_found && walk_end && act_set && can_new && (tomb_seen_q || !live);

	// result of the slot under check
	always_comb begin
		res_nx.hit        = (key_found && !act_set) || ins_ok;
		res_nx.read_value = (key_found && item_q.action == oaht_pkg::ACT_GET) ? val_rd_q : '0;
		res_nx.status     = !key_found && walk_end && act_set && !ins_ok;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			oaht_pkg::ST_IDLE: begin
				if (accept_in) begin
					if (in_data.action == oaht_pkg::ACT_CLR)
						state_nx = oaht_pkg::ST_CLEAR;
					else
						state_nx = oaht_pkg::ST_READ;
				end
			end
			oaht_pkg::ST_READ:  state_nx = oaht_pkg::ST_CHECK;
			oaht_pkg::ST_CHECK: begin
				if (key_found || walk_end)
					state_nx = oaht_pkg::ST_WRITE;
				else
					state_nx = oaht_pkg::ST_READ;
			end
			oaht_pkg::ST_WRITE: state_nx = oaht_pkg::ST_DONE;
			oaht_pkg::ST_CLEAR: begin
				if (idx_q == LAST)
					state_nx = oaht_pkg::ST_DONE;
			end
			oaht_pkg::ST_DONE: begin
				if (out_free)
					state_nx = oaht_pkg::ST_IDLE;
			end
			default: state_nx = oaht_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oaht_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	// memory reads, registered
	always_ff @(posedge clk) begin
		st_rd_q  <= st_mem[idx_q];
		key_rd_q <= key_mem[idx_q];
		val_rd_q <= val_mem[idx_q];
	end

	// memory writes: clear sweep or item update
	always_ff @(posedge clk) begin
		if (state_q == oaht_pkg::ST_CLEAR) begin
			st_mem[idx_q] <= 2'b00;
		end else if (state_q == oaht_pkg::ST_WRITE) begin
			if (wr_live_q || wr_tomb_q)
				st_mem[wr_at_q] <= {wr_live_q, wr_tomb_q};
			if (wr_kv_q) begin
				if (wr_live_q)
					key_mem[wr_at_q] <= item_q.key_id;
				val_mem[wr_at_q] <= item_q.write_value;
			end
		end
	end

	// probe control, counters and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q      <= '0;
			idx_q       <= '0;
			tomb_at_q   <= '0;
			wr_at_q     <= '0;
			steps_q     <= '0;
			tomb_seen_q <= 1'b0;
			used_q      <= '0;
			max_used_q  <= oaht_pkg::MAX_USED_RESET;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			res_q       <= '0;
			wr_live_q   <= 1'b0;
			wr_tomb_q   <= 1'b0;
			wr_kv_q     <= 1'b0;
			wr_inc_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				max_used_q <= cfg_data;
			// load a finished result, or drop the one just transferred
			if (state_q == oaht_pkg::ST_DONE && out_free)
				out_valid_q <= !boot_q;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				oaht_pkg::ST_IDLE: begin
					if (accept_in) begin
						item_q      <= in_data;
						idx_q       <= (in_data.action == oaht_pkg::ACT_CLR) ? '0 :
						               in_data.key_hash[AW-1:0];
						steps_q     <= '0;
						tomb_seen_q <= 1'b0;
						res_q       <= '0;
					end
				end
				oaht_pkg::ST_CHECK: begin
					res_q     <= res_nx;
					wr_live_q <= ins_ok;
					wr_tomb_q <= key_found && (item_q.action == oaht_pkg::ACT_DEL);
					wr_kv_q   <= ins_ok || (key_found && act_set);
					wr_inc_q  <= ins_ok && !tomb_seen_q && !tomb;
					wr_at_q   <= (tomb_seen_q && !key_found) ? tomb_at_q : idx_q;
					if (!key_found && !walk_end) begin
						// advance the probe
						if (tomb && !tomb_seen_q) begin
							tomb_seen_q <= 1'b1;
							tomb_at_q   <= idx_q;
						end
						idx_q   <= idx_nx;
						steps_q <= steps_q + CW'(1);
					end
				end
				oaht_pkg::ST_WRITE: begin
					if (wr_inc_q)
						used_q <= used_q + 9'd1;
				end
				oaht_pkg::ST_CLEAR: begin
					idx_q  <= idx_nx;
					used_q <= '0;
				end
				oaht_pkg::ST_DONE: begin
					if (out_free)
						out_q <= res_q;
				end
				default: ;
			endcase
		end
	end

	// Drop the result of the sweep that follows reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			boot_q <= 1'b1;
		else if (state_q == oaht_pkg::ST_DONE)
			boot_q <= 1'b0;
	end

	`OAHT_ASSERT_IMP(a_no_take_busy, clk, arst_n, state_q != oaht_pkg::ST_IDLE, !accept_in,
		"item accepted while busy")
	`OAHT_ASSERT_IMP(a_used_bound, clk, arst_n, 1'b1, used_q <= 9'(CAPACITY),
		"used count over capacity")
	`OAHT_ASSERT_NEXT(a_out_held, clk, arst_n, out_valid_q && out_stall, out_valid_q && $stable(out_q),
		"stalled result changed")

endmodule

[sim/tb_open_addressing_hash_table.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_open_addressing_hash_table
// Self-checking bench for the linear probing table: sends set, get, delete
// and clear transfers, predicts every result in its own table copy and
// compares each received transfer field by field.
// ---------------------------------------------------------------------------
module tb_open_addressing_hash_table;

	localparam int SLOTS = oaht_pkg::CAPACITY;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	oaht_pkg::in_item_t  in_data;
	logic                out_valid;
	logic                out_stall;
	oaht_pkg::out_item_t out_data;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [8:0]          cfg_data;

	// Shadow copy of the table
	bit          tbl_live [SLOTS];
	bit          tbl_tomb [SLOTS];
	logic [31:0] tbl_key [SLOTS];
	logic [63:0] tbl_val [SLOTS];
	int unsigned tbl_used;
	int unsigned load_limit;

	oaht_pkg::out_item_t pending_results[$];
	int unsigned mismatch_count;
	bit          quiet_mode;
	bit          rx_idle_enable;

	open_addressing_hash_table dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Clear the shadow table
	function automatic void wipe_table();
		for (int i = 0; i < SLOTS; i++) begin
			tbl_live[i] = 0;
			tbl_tomb[i] = 0;
		end
		tbl_used = 0;
	endfunction

	// Work out the result of one transfer and update the shadow table
	function automatic oaht_pkg::out_item_t apply_action(oaht_pkg::in_item_t it);
		oaht_pkg::out_item_t r;
		int unsigned idx;
		bit found, has_free, tomb_seen;
		int unsigned found_at, free_at, tomb_at;
		r = '0;
		found = 0;
		has_free = 0;
		tomb_seen = 0;
		found_at = 0;
		free_at = 0;
		tomb_at = 0;
		if (oaht_pkg::action_t'(it.action) == oaht_pkg::ACT_CLR) begin
			wipe_table();
			return r;
		end
		idx = it.key_hash % SLOTS;
		for (int n = 0; n < SLOTS; n++) begin
			if (tbl_live[idx]) begin
				if (tbl_key[idx] == it.key_id) begin
					found = 1;
					found_at = idx;
					break;
				end
			end else if (tbl_tomb[idx]) begin
				if (!tomb_seen) begin
					tomb_seen = 1;
					tomb_at = idx;
				end
			end else begin
				has_free = 1;
				free_at = tomb_seen ? tomb_at : idx;
				break;
			end
			idx = (idx + 1) % SLOTS;
		end
		if (!found && !has_free && tomb_seen) begin
			has_free = 1;
			free_at = tomb_at;
		end
		case (oaht_pkg::action_t'(it.action))
			oaht_pkg::ACT_SET: begin
				if (found) begin
					tbl_val[found_at] = it.write_value;
				end else if (tbl_used >= load_limit || !has_free) begin
					r.status = 1'b1;
				end else begin
					if (!tbl_tomb[free_at])
						tbl_used++;
					tbl_tomb[free_at] = 0;
					tbl_live[free_at] = 1;
					tbl_key[free_at] = it.key_id;
					tbl_val[free_at] = it.write_value;
					r.hit = 1'b1;
				end
			end
			oaht_pkg::ACT_GET: begin
				if (found) begin
					r.hit = 1'b1;
					r.read_value = tbl_val[found_at];
				end
			end
			default: begin
				if (found) begin
					tbl_live[found_at] = 0;
					tbl_tomb[found_at] = 1;
					r.hit = 1'b1;
				end
			end
		endcase
		return r;
	endfunction

	// Send one transfer, at times after a random idle burst (never in quiet
	// mode); valid then stays high until the next item or an explicit idle
	task automatic send_item(oaht_pkg::action_t act, logic [31:0] key, logic [31:0] hash,
			logic [63:0] val);
		oaht_pkg::in_item_t it;
		if (!quiet_mode && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		it.action = act;
		it.key_id = key;
		it.key_hash = hash;
		it.write_value = val;
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(apply_action(it));
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// Wait for all results, then a margin, and write the load limit
	task automatic write_limit(int unsigned lim);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (2 * SLOTS + 8) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= lim[8:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		load_limit = lim;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Extremes of the fields and every action
	task automatic test_directed();
		send_item(oaht_pkg::ACT_GET, 32'h0, 32'h0, 64'h0);
		send_item(oaht_pkg::ACT_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(oaht_pkg::ACT_SET, 32'h0, 32'hFFFF_FFFF, 64'h0);
		send_item(oaht_pkg::ACT_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0);
		send_item(oaht_pkg::ACT_GET, 32'h0, 32'hFFFF_FFFF, 64'h0);
		// overwrite an existing key
		send_item(oaht_pkg::ACT_SET, 32'h0, 32'hFFFF_FFFF, 64'h1234_5678_9ABC_DEF0);
		send_item(oaht_pkg::ACT_GET, 32'h0, 32'hFFFF_FFFF, 64'h0);
		// delete, then reuse the tombstone
		send_item(oaht_pkg::ACT_DEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0);
		send_item(oaht_pkg::ACT_DEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0);
		send_item(oaht_pkg::ACT_GET, 32'h0, 32'hFFFF_FFFF, 64'h0);
		send_item(oaht_pkg::ACT_SET, 32'h55, 32'h0000_00FF, 64'h5555);
		send_item(oaht_pkg::ACT_GET, 32'h55, 32'h0000_00FF, 64'h0);
		send_item(oaht_pkg::ACT_CLR, 32'h0, 32'h0, 64'h0);
		send_item(oaht_pkg::ACT_GET, 32'h55, 32'h0000_00FF, 64'h0);
	endtask

	// Mostly small key sets with colliding hashes
	task automatic test_random(int unsigned count, int unsigned keys);
		logic [31:0] k;
		logic [31:0] h;
		int unsigned pick;
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(0, keys - 1);
			h = (k * 32'd7) ^ ($urandom & 32'hFFFF_FF00);
			h[7:0] = k[7:0] & 8'h1F;
			if ($urandom_range(0, 9) == 0) begin
				k = $urandom;
				h = $urandom;
			end
			pick = $urandom_range(0, 99);
			if (pick < 45)
				send_item(oaht_pkg::ACT_SET, k, h, rand_word());
			else if (pick < 75)
				send_item(oaht_pkg::ACT_GET, k, h, rand_word());
			else if (pick < 99)
				send_item(oaht_pkg::ACT_DEL, k, h, rand_word());
			else
				send_item(oaht_pkg::ACT_CLR, $urandom, $urandom, rand_word());
		end
	endtask

	// Fill to the load limit and beyond
	task automatic test_fill(int unsigned count);
		for (int i = 0; i < count; i++)
			send_item(oaht_pkg::ACT_SET, $urandom, $urandom, rand_word());
	endtask

	// Receiver: random stall bursts
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_idle_enable && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Compare each received transfer with the oldest prediction
	always @(posedge clk) begin
		oaht_pkg::out_item_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: expected no result, got %h", $time, out_data);
				mismatch_count++;
			end else begin
				exp_res = pending_results.pop_front();
				if (out_data.hit !== exp_res.hit ||
						out_data.read_value !== exp_res.read_value ||
						out_data.status !== exp_res.status) begin
					$display("%0t: expected hit %b value %h status %b, %s %b %s %h %s %b",
						$time, exp_res.hit, exp_res.read_value, exp_res.status,
						"got hit", out_data.hit, "value", out_data.read_value,
						"status", out_data.status);
					mismatch_count++;
				end
			end
		end
	end

	// Sequence of tests
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		mismatch_count = 0;
		quiet_mode = 0;
		rx_idle_enable = 1;
		load_limit = oaht_pkg::MAX_USED_RESET;
		wipe_table();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random(500, 40);
		test_fill(220);
		test_random(100, 300);
		write_limit(1);
		send_item(oaht_pkg::ACT_CLR, '0, '0, '0);
		test_random(60, 4);
		write_limit(256);
		send_item(oaht_pkg::ACT_CLR, '0, '0, '0);
		test_fill(270);
		test_random(100, 50);
		write_limit(0);
		test_random(40, 50);
		write_limit(20);
		send_item(oaht_pkg::ACT_CLR, '0, '0, '0);
		test_random(300, 60);
		write_limit(192);
		quiet_mode = 1;
		rx_idle_enable = 0;
		test_random(300, 100);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (2 * SLOTS + 8) @(negedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog
	initial begin
		#80ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/oaht_pkg.sv
rtl/core/open_addressing_hash_table.sv
sim/tb_open_addressing_hash_table.sv
